// ----- rtl/hntlp_pkg.sv -----
// Shared types and constants of the hashed name table.
// Depends on nothing; the front end, queue, probe engine and top level import it.
`timescale 1ns / 1ps

package hntlp_pkg;

  localparam int TABLE_SIZE = 256;
  localparam int NAME_BYTES = 16;
  localparam int IDX_W = $clog2(TABLE_SIZE);
  localparam int KEY_W = 128;

  localparam logic [31:0] FNV_BASIS = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME = 32'd16777619;

  // Home slot is a plain mask of the hash when the table is a power of two.
  localparam bit TABLE_POW2 = (TABLE_SIZE & (TABLE_SIZE - 1)) == 0;

  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_FOUND     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic {
    CMD_REGISTER = 1'b0,
    CMD_LOOKUP   = 1'b1
  } cmd_t;

  typedef logic [IDX_W-1:0] idx_t;

  // Classified request handed from the front end to the probe engine.
  typedef struct packed {
    cmd_t             cmd;
    logic [KEY_W-1:0] key;
    logic [31:0]      value;
    idx_t             home;
  } job_t;

endpackage

// ----- rtl/hntlp_if.sv -----
// Request and response channel interfaces of the hashed name table.
// Depends on nothing; used by the front end, the probe engine and the top level.
`timescale 1ns / 1ps

interface hntlp_req_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [63:0] name_lo;
  logic [63:0] name_hi;
  logic [31:0] new_value;

  modport source (output valid, cmd, name_lo, name_hi, new_value, input ready);
  modport sink   (input valid, cmd, name_lo, name_hi, new_value, output ready);
endinterface

interface hntlp_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [7:0]  slot;
  logic [31:0] entry_value;

  modport source (output valid, status, slot, entry_value, input ready);
  modport sink   (input valid, status, slot, entry_value, output ready);
endinterface

// ----- rtl/hntlp_front.sv -----
// Front end: accept a request, cut the name at its terminator, FNV-1a hash it
// and reduce the hash to a home slot. Depends on hntlp_pkg and hntlp_if.
`timescale 1ns / 1ps

module hntlp_front
  import hntlp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  hntlp_req_if.sink   req,
  output logic        job_valid,
  input  logic        job_ready,
  output job_t        job
);

  localparam int CNT_W = $clog2(NAME_BYTES + 1);
  localparam logic [KEY_W-1:0] LEN_MASK =
    (KEY_W'(1) << (8 * NAME_BYTES)) - KEY_W'(1);

  typedef enum logic [1:0] {F_IDLE, F_HASH, F_MOD, F_OUT} fstate_t;

  fstate_t          state;
  cmd_t             cmd_r;
  logic [KEY_W-1:0] name_r;
  logic [31:0]      value_r;
  logic [31:0]      hash;
  logic [CNT_W-1:0] cnt;
  logic [IDX_W:0]   rem;
  logic [4:0]       bitcnt;
  idx_t             home;

  logic [6:0]       byte_sel;
  logic [7:0]       cur_byte;
  logic [31:0]      prod;
  logic [KEY_W-1:0] keep_mask;
  logic [IDX_W:0]   rem_shift;
  logic [IDX_W:0]   rem_next;

  assign byte_sel  = {4'(cnt), 3'b000};
  assign cur_byte  = name_r[byte_sel +: 8];
  assign prod      = (hash ^ {24'd0, cur_byte}) * FNV_PRIME;
  assign keep_mask = (KEY_W'(1) << byte_sel) - KEY_W'(1);

  // One restoring remainder step per cycle, hash bits taken from the top.
  assign rem_shift = {rem[IDX_W-1:0], hash[31]};
  assign rem_next  = (rem_shift >= (IDX_W + 1)'(TABLE_SIZE))
                   ? rem_shift - (IDX_W + 1)'(TABLE_SIZE) : rem_shift;

  assign req.ready = (state == F_IDLE);
  assign job_valid = (state == F_OUT);
  assign job.cmd   = cmd_r;
  assign job.key   = name_r;
  assign job.value = value_r;
  assign job.home  = home;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (req.valid) begin
            cmd_r   <= cmd_t'(req.cmd);
            name_r  <= {req.name_hi, req.name_lo} & LEN_MASK;
            value_r <= req.new_value;
            hash    <= FNV_BASIS;
            cnt     <= '0;
            rem     <= '0;
            bitcnt  <= '0;
            state   <= F_HASH;
          end
        end
        F_HASH: begin
          if (cur_byte == 8'd0) begin
            // drop everything from the terminator on
            name_r <= name_r & keep_mask;
            state  <= F_MOD;
          end else begin
            hash <= prod;
            if (cnt == CNT_W'(NAME_BYTES - 1)) begin
              state <= F_MOD;
            end else begin
              cnt <= cnt + CNT_W'(1);
            end
          end
        end
        F_MOD: begin
          if (TABLE_POW2) begin
            home  <= hash[IDX_W-1:0];
            state <= F_OUT;
          end else begin
            rem    <= rem_next;
            hash   <= {hash[30:0], 1'b0};
            bitcnt <= bitcnt + 5'd1;
            if (bitcnt == 5'd31) begin
              home  <= rem_next[IDX_W-1:0];
              state <= F_OUT;
            end
          end
        end
        F_OUT: begin
          if (job_ready) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/hntlp_queue.sv -----
// Two-entry queue of classified requests between front end and probe engine.
// Depends on hntlp_pkg.
`timescale 1ns / 1ps

module hntlp_queue
  import hntlp_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  job_t in_job,
  output logic out_valid,
  input  logic out_ready,
  output job_t out_job
);

  job_t       entries [2];
  logic       wp;
  logic       rp;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_job   = entries[rp];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wp] <= in_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- rtl/hntlp_back.sv -----
// Probe engine: owns the slot memories, walks the linear probe path and
// registers one response per request. Depends on hntlp_pkg and hntlp_if.
`timescale 1ns / 1ps

module hntlp_back
  import hntlp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        job_valid,
  output logic        job_ready,
  input  job_t        job,
  hntlp_rsp_if.source rsp
);

  typedef enum logic [1:0] {B_CLEAR, B_IDLE, B_READ, B_EVAL} bstate_t;

  localparam idx_t LAST = IDX_W'(TABLE_SIZE - 1);

  logic             used_mem [TABLE_SIZE];
  logic [KEY_W-1:0] key_mem  [TABLE_SIZE];
  logic [31:0]      val_mem  [TABLE_SIZE];

  bstate_t          state;
  idx_t             pos;
  idx_t             step;
  cmd_t             cmd_r;
  logic [KEY_W-1:0] key_r;
  logic [31:0]      value_r;

  logic             used_q;
  logic [KEY_W-1:0] key_q;
  logic [31:0]      val_q;

  logic             rsp_valid;
  status_t          rsp_status;
  logic [7:0]       rsp_slot;
  logic [31:0]      rsp_value;

  idx_t             pos_inc;
  logic             match;
  logic             finish;
  logic             out_free;
  logic             load;
  logic             ins_we;

  assign pos_inc  = (pos == LAST) ? '0 : pos + IDX_W'(1);
  assign match    = (key_q == key_r);
  assign finish   = !used_q || match || (step == LAST);
  assign out_free = !rsp_valid || rsp.ready;
  assign load     = (state == B_EVAL) && finish && out_free;
  assign ins_we   = load && !used_q && (cmd_r == CMD_REGISTER);

  assign job_ready       = (state == B_IDLE);
  assign rsp.valid       = rsp_valid;
  assign rsp.status      = rsp_status;
  assign rsp.slot        = rsp_slot;
  assign rsp.entry_value = rsp_value;

  // Slot memories: one write port, one registered read port at pos.
  always_ff @(posedge clk) begin
    if (state == B_CLEAR) begin
      used_mem[pos] <= 1'b0;
    end else if (ins_we) begin
      used_mem[pos] <= 1'b1;
    end
    if (ins_we) begin
      key_mem[pos] <= key_r;
      val_mem[pos] <= value_r;
    end
    if (state == B_READ) begin
      used_q <= used_mem[pos];
      key_q  <= key_mem[pos];
      val_q  <= val_mem[pos];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_CLEAR;
      pos       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && rsp.ready && !load) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        B_CLEAR: begin
          pos <= pos_inc;
          if (pos == LAST) begin
            state <= B_IDLE;
          end
        end
        B_IDLE: begin
          if (job_valid) begin
            cmd_r   <= job.cmd;
            key_r   <= job.key;
            value_r <= job.value;
            pos     <= job.home;
            step    <= '0;
            state   <= B_READ;
          end
        end
        B_READ: begin
          state <= B_EVAL;
        end
        B_EVAL: begin
          if (!finish) begin
            pos   <= pos_inc;
            step  <= step + IDX_W'(1);
            state <= B_READ;
          end else if (out_free) begin
            rsp_valid <= 1'b1;
            state     <= B_IDLE;
            priority if (!used_q && cmd_r == CMD_LOOKUP) begin
              rsp_status <= ST_NOT_FOUND;
              rsp_slot   <= 8'd0;
              rsp_value  <= 32'd0;
            end else if (!used_q) begin
              rsp_status <= ST_INSERTED;
              rsp_slot   <= 8'(pos);
              rsp_value  <= value_r;
            end else if (match) begin
              rsp_status <= ST_FOUND;
              rsp_slot   <= 8'(pos);
              rsp_value  <= val_q;
            end else begin
              rsp_status <= (cmd_r == CMD_LOOKUP) ? ST_NOT_FOUND : ST_FULL;
              rsp_slot   <= 8'd0;
              rsp_value  <= 32'd0;
            end
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/hashed_name_table_linear_probe.sv -----
// Top level of the hashed name table: front end, request queue, probe engine.
// Depends on hntlp_pkg, hntlp_if, hntlp_front, hntlp_queue and hntlp_back.
`timescale 1ns / 1ps

// Open-addressed name table of TABLE_SIZE (256) slots. Each request carries a
// name of up to 16 bytes; the name ends at its first zero byte and later bytes
// are ignored. A register request stores the name with new_value in the first
// free slot on its probe path, or reports the entry already there (the stored
// value is kept); a look-up request stops at the first free slot. Every
// request gives exactly one response: status, slot and entry_value, with slot
// and value zero for not found and table full. The front end takes one request
// at a time: its FNV-1a multiply loop takes in the name bytes one after
// another until the terminator or the sixteenth byte, then it reduces the hash
// to a home slot and hands the job off, and it is free for the next request
// once the queue has taken that job. A two-entry queue then feeds the probe
// engine, which takes the request and, for each probed slot, reads the memory
// and then compares, so its time grows with the probe run length and is
// longest on a full table. After reset the probe engine clears the used mark
// of every slot; requests are still accepted into the front end and queue in
// that time, and answered once the pass is over. A finished response waits in
// an output register while the next request proceeds.
module hashed_name_table_linear_probe
  import hntlp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  hntlp_req_if.sink   req,
  hntlp_rsp_if.source rsp
);

  logic f_valid;
  logic f_ready;
  job_t f_job;
  logic q_valid;
  logic q_ready;
  job_t q_job;

  // Hash and classify incoming requests.
  hntlp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .job_valid (f_valid),
    .job_ready (f_ready),
    .job       (f_job)
  );

  // Decouple hashing from probing so each side stalls on its own.
  hntlp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_job    (f_job),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_job   (q_job)
  );

  // Walk the probe path and register the response.
  hntlp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (q_valid),
    .job_ready (q_ready),
    .job       (q_job),
    .rsp       (rsp)
  );

  // A miss or a full table never reports a slot or a value.
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && (rsp.status == ST_NOT_FOUND || rsp.status == ST_FULL)
      |-> (rsp.slot == 8'd0) && (rsp.entry_value == 32'd0))
    else $error("miss response carries slot or value");

  // No response can be pending right after reset.
  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !rsp.valid)
    else $error("response valid right after reset");

  // The probe engine is still in its clearing pass just after reset, so no
  // response is released then even with a request queued.
  a_clear_holds: assert property (@(posedge clk)
    $past(rst, 2) && $past(rst) |=> !rsp.valid)
    else $error("response during clearing pass");

endmodule
